// ===== src/tvis_pkg.sv =====
// Shared types, constants and a helper function of the two-valve irrigation sequencer.
package tvis_pkg;

   // Field widths
   localparam int unsigned OpWidth       = 3;
   localparam int unsigned ReadingWidth  = 10;
   localparam int unsigned ThreshWidth   = 10;
   localparam int unsigned LimitWidth    = 4;
   localparam int unsigned TicksWidth    = 32;
   localparam int unsigned HumidityWidth = 7;
   localparam int unsigned CountWidth    = 4;
   localparam int unsigned CsrIndexWidth = 8;
   localparam int unsigned CsrDataWidth  = 32;

   // Register reset values
   localparam logic [ThreshWidth-1:0] DryThresholdReset  = 10'd768;
   localparam logic [LimitWidth-1:0]  DryCountLimitReset = 4'd7;
   localparam logic [TicksWidth-1:0]  ValveOneTicksReset = 32'd1200000;
   localparam logic [TicksWidth-1:0]  ValveTwoTicksReset = 32'd1500000;

   // Humidity scaling
   localparam int unsigned SensorFullScale = 1023;
   localparam int unsigned PercentScale    = 100;

   // Operation codes of a request beat
   typedef enum logic [OpWidth-1:0] {
      OP_SAMPLE       = 3'd0,
      OP_V1_ON        = 3'd1,
      OP_V1_OFF       = 3'd2,
      OP_V2_ON        = 3'd3,
      OP_V2_OFF       = 3'd4,
      OP_CHAIN_TOGGLE = 3'd5,
      OP_AUTO_TOGGLE  = 3'd6,
      OP_STATUS       = 3'd7
   } op_type;

   // Configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DRY_THRESHOLD   = 8'd0,
      CSR_DRY_COUNT_LIMIT = 8'd1,
      CSR_VALVE_ONE_TICKS = 8'd2,
      CSR_VALVE_TWO_TICKS = 8'd3
   } csr_index_type;

   // Configuration seen by the step logic
   typedef struct packed {
      logic [ThreshWidth-1:0] dry_threshold;
      logic [LimitWidth-1:0]  dry_count_limit;
      logic [TicksWidth-1:0]  valve_one_ticks;
      logic [TicksWidth-1:0]  valve_two_ticks;
   } cfg_type;

   // One result beat
   typedef struct packed {
      logic                     valve_one_open;
      logic                     valve_two_open;
      logic                     chain_enabled;
      logic                     auto_enabled;
      logic                     chained_now;
      logic                     suspended_now;
      logic [HumidityWidth-1:0] humidity_percent;
      logic [CountWidth-1:0]    dry_run_count;
   } result_type;

   // 100 - reading*100/1023, with the divide done as a shift plus one correction:
   // x = q*1024 + lo = q*1023 + (lo + q), and lo + q stays below 2*1023.
   function automatic logic [HumidityWidth-1:0] humidity_of(
      input logic [ReadingWidth-1:0] reading
   );
      logic [16:0]              scaled;
      logic [6:0]               quo_est;
      logic [10:0]              rem;
      logic [HumidityWidth-1:0] quo;
      scaled  = 17'(reading) * 17'(PercentScale);
      quo_est = scaled[16:10];
      rem     = 11'(scaled[9:0]) + 11'(quo_est);
      quo     = (rem >= 11'(SensorFullScale)) ? quo_est + 7'd1 : quo_est;
      return 7'(PercentScale) - quo;
   endfunction

endpackage

// ===== src/tvis_intf.sv =====
// Handshake interfaces for the request, response and configuration channels.
interface tvis_req_intf;
   logic                                valid;
   logic                                ready;
   logic [tvis_pkg::OpWidth-1:0]        operation;
   logic [tvis_pkg::ReadingWidth-1:0]   moisture_reading;

   modport source (output valid, operation, moisture_reading, input ready);
   modport sink   (input valid, operation, moisture_reading, output ready);
endinterface

interface tvis_rsp_intf;
   logic                                valid;
   logic                                ready;
   logic                                valve_one_open;
   logic                                valve_two_open;
   logic                                chain_enabled;
   logic                                auto_enabled;
   logic                                chained_now;
   logic                                suspended_now;
   logic [tvis_pkg::HumidityWidth-1:0]  humidity_percent;
   logic [tvis_pkg::CountWidth-1:0]     dry_run_count;

   modport source (output valid, valve_one_open, valve_two_open, chain_enabled,
                   auto_enabled, chained_now, suspended_now, humidity_percent,
                   dry_run_count, input ready);
   modport sink   (input valid, valve_one_open, valve_two_open, chain_enabled,
                   auto_enabled, chained_now, suspended_now, humidity_percent,
                   dry_run_count, output ready);
endinterface

interface tvis_csr_intf;
   logic                                valid;
   logic                                ready;
   logic [tvis_pkg::CsrIndexWidth-1:0]  index;
   logic [tvis_pkg::CsrDataWidth-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/two_valve_irrigation_sequencer.sv =====
// A request beat waits in the input register until the output register is free or taken,
// then its result is loaded there. Throughput: one beat per cycle while the response side
// keeps taking beats; the input register refills while the output register is taken, and
// the state update between them is a combinational compare and decrement.
// Reset: synchronous, active high; valves closed, timers and dry count zero, chaining and
// auto mode on, configuration registers back to their defaults. No clearing pass.
module two_valve_irrigation_sequencer (
   input  logic         clock,
   input  logic         reset,
   tvis_req_intf.sink   req_if,
   tvis_rsp_intf.source rsp_if,
   tvis_csr_intf.sink   csr_if
);

   logic                                in_valid_ff, in_valid_in;
   logic [tvis_pkg::OpWidth-1:0]        in_op_ff, in_op_in;
   logic [tvis_pkg::ReadingWidth-1:0]   in_reading_ff, in_reading_in;
   logic                                out_valid_ff, out_valid_in;
   tvis_pkg::result_type                out_ff, out_in;

   tvis_pkg::cfg_type                   cfg;
   tvis_pkg::result_type                step_result;
   logic                                advance;
   logic                                req_take;

   tvis_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   tvis_core u_core (
      .clock            (clock),
      .reset            (reset),
      .step_en          (advance),
      .operation        (in_op_ff),
      .moisture_reading (in_reading_ff),
      .cfg              (cfg),
      .result           (step_result)
   );

   // Handshake: process the held beat when the output slot frees up
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   // Input register
   always_comb begin
      in_valid_in   = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_op_in      = req_take ? req_if.operation : in_op_ff;
      in_reading_in = req_take ? req_if.moisture_reading : in_reading_ff;
   end

   // Output register
   always_comb begin
      out_valid_in = advance ? 1'b1 : ((out_valid_ff && !rsp_if.ready) ? 1'b1 : 1'b0);
      out_in       = advance ? step_result : out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff      <= in_op_in;
      in_reading_ff <= in_reading_in;
      out_ff        <= out_in;
   end

   // Response beat
   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.valve_one_open   = out_ff.valve_one_open;
   assign rsp_if.valve_two_open   = out_ff.valve_two_open;
   assign rsp_if.chain_enabled    = out_ff.chain_enabled;
   assign rsp_if.auto_enabled     = out_ff.auto_enabled;
   assign rsp_if.chained_now      = out_ff.chained_now;
   assign rsp_if.suspended_now    = out_ff.suspended_now;
   assign rsp_if.humidity_percent = out_ff.humidity_percent;
   assign rsp_if.dry_run_count    = out_ff.dry_run_count;

`ifndef NO_ASSERTIONS
   // a chained step always leaves valve two open
   a_chain_opens_v2: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.chained_now) |-> out_ff.valve_two_open)
      else $error("chained step left valve two closed");

   // a suspend step always reports auto mode off
   a_suspend_clears_auto: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.suspended_now) |-> !out_ff.auto_enabled)
      else $error("suspended step reports auto mode on");

   // full input register and stalled output must block new requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_if.ready) |-> !req_if.ready)
      else $error("request accepted while both stages are held");

   // humidity stays within percent range
   a_humidity_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.humidity_percent <= 7'd100))
      else $error("humidity percent out of range");
`endif

endmodule

// ===== src/tvis_csr.sv =====
// Configuration register file: dry threshold, dry count limit and valve durations.
module tvis_csr (
   input  logic                 clock,
   input  logic                 reset,
   tvis_csr_intf.sink           csr_if,
   output tvis_pkg::cfg_type    cfg
);

   tvis_pkg::cfg_type cfg_ff;
   tvis_pkg::cfg_type cfg_in;

   // Writes are always accepted; the register file never stalls
   assign csr_if.ready = 1'b1;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (tvis_pkg::csr_index_type'(csr_if.index))
            tvis_pkg::CSR_DRY_THRESHOLD:
               cfg_in.dry_threshold = csr_if.data[tvis_pkg::ThreshWidth-1:0];
            tvis_pkg::CSR_DRY_COUNT_LIMIT:
               cfg_in.dry_count_limit = csr_if.data[tvis_pkg::LimitWidth-1:0];
            tvis_pkg::CSR_VALVE_ONE_TICKS:
               cfg_in.valve_one_ticks = csr_if.data[tvis_pkg::TicksWidth-1:0];
            tvis_pkg::CSR_VALVE_TWO_TICKS:
               cfg_in.valve_two_ticks = csr_if.data[tvis_pkg::TicksWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dry_threshold   <= tvis_pkg::DryThresholdReset;
         cfg_ff.dry_count_limit <= tvis_pkg::DryCountLimitReset;
         cfg_ff.valve_one_ticks <= tvis_pkg::ValveOneTicksReset;
         cfg_ff.valve_two_ticks <= tvis_pkg::ValveTwoTicksReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/tvis_core.sv =====
// Valve state, timers, dry run counter and the per-beat update logic.
module tvis_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step_en,
   input  logic [tvis_pkg::OpWidth-1:0]         operation,
   input  logic [tvis_pkg::ReadingWidth-1:0]    moisture_reading,
   input  tvis_pkg::cfg_type                    cfg,
   output tvis_pkg::result_type                 result
);

   logic                               v1_open_ff, v1_open_in;
   logic                               v2_open_ff, v2_open_in;
   logic [tvis_pkg::TicksWidth-1:0]    v1_rem_ff, v1_rem_in;
   logic [tvis_pkg::TicksWidth-1:0]    v2_rem_ff, v2_rem_in;
   logic [tvis_pkg::CountWidth-1:0]    dry_cnt_ff, dry_cnt_in;
   logic                               chain_ff, chain_in;
   logic                               auto_ff, auto_in;

   logic                               dry;
   logic                               chained;
   logic                               suspended;
   logic [tvis_pkg::LimitWidth-1:0]    limit;

   assign dry   = (moisture_reading >= cfg.dry_threshold);
   assign limit = (cfg.dry_count_limit == '0) ? tvis_pkg::LimitWidth'(1)
                                              : cfg.dry_count_limit;

   // Next state for one beat
   always_comb begin
      v1_open_in = v1_open_ff;
      v2_open_in = v2_open_ff;
      v1_rem_in  = v1_rem_ff;
      v2_rem_in  = v2_rem_ff;
      dry_cnt_in = dry_cnt_ff;
      chain_in   = chain_ff;
      auto_in    = auto_ff;
      chained    = 1'b0;
      suspended  = 1'b0;
      unique case (tvis_pkg::op_type'(operation))
         tvis_pkg::OP_SAMPLE: begin
            // valve two timer first, so a chain below restarts it
            if (v2_open_ff) begin
               if (v2_rem_ff <= 32'd1) begin
                  v2_open_in = 1'b0;
                  v2_rem_in  = '0;
               end else begin
                  v2_rem_in = v2_rem_ff - 32'd1;
               end
            end
            // valve one timer, chain and auto suspend on expiry
            if (v1_open_ff) begin
               if (v1_rem_ff <= 32'd1) begin
                  v1_open_in = 1'b0;
                  v1_rem_in  = '0;
                  if (chain_ff) begin
                     v2_open_in = 1'b1;
                     v2_rem_in  = cfg.valve_two_ticks;
                     chained    = 1'b1;
                  end
                  if (dry) begin
                     auto_in   = 1'b0;
                     suspended = 1'b1;
                  end
               end else begin
                  v1_rem_in = v1_rem_ff - 32'd1;
               end
            end
            // saturating dry run count
            if (dry) begin
               if (dry_cnt_ff < limit) begin
                  dry_cnt_in = dry_cnt_ff + 4'd1;
               end
            end else begin
               dry_cnt_in = '0;
            end
            // automatic start
            if (!v1_open_in && !v2_open_in && auto_in && (dry_cnt_in == limit)) begin
               v1_open_in = 1'b1;
               v1_rem_in  = cfg.valve_one_ticks;
            end
         end
         tvis_pkg::OP_V1_ON: begin
            v1_open_in = 1'b1;
            v1_rem_in  = cfg.valve_one_ticks;
         end
         tvis_pkg::OP_V1_OFF: begin
            v1_open_in = 1'b0;
            v1_rem_in  = '0;
         end
         tvis_pkg::OP_V2_ON: begin
            v2_open_in = 1'b1;
            v2_rem_in  = cfg.valve_two_ticks;
         end
         tvis_pkg::OP_V2_OFF: begin
            v2_open_in = 1'b0;
            v2_rem_in  = '0;
         end
         tvis_pkg::OP_CHAIN_TOGGLE: chain_in = !chain_ff;
         tvis_pkg::OP_AUTO_TOGGLE:  auto_in  = !auto_ff;
         tvis_pkg::OP_STATUS: ;
      endcase
   end

   // State registers, updated once per processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_open_ff <= 1'b0;
         v2_open_ff <= 1'b0;
         v1_rem_ff  <= '0;
         v2_rem_ff  <= '0;
         dry_cnt_ff <= '0;
         chain_ff   <= 1'b1;
         auto_ff    <= 1'b1;
      end else if (step_en) begin
         v1_open_ff <= v1_open_in;
         v2_open_ff <= v2_open_in;
         v1_rem_ff  <= v1_rem_in;
         v2_rem_ff  <= v2_rem_in;
         dry_cnt_ff <= dry_cnt_in;
         chain_ff   <= chain_in;
         auto_ff    <= auto_in;
      end
   end

   // Result of this beat
   always_comb begin
      result.valve_one_open   = v1_open_in;
      result.valve_two_open   = v2_open_in;
      result.chain_enabled    = chain_in;
      result.auto_enabled     = auto_in;
      result.chained_now      = chained;
      result.suspended_now    = suspended;
      result.humidity_percent = tvis_pkg::humidity_of(moisture_reading);
      result.dry_run_count    = dry_cnt_in;
   end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the two-valve irrigation sequencer.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned CycleLimit   = 200000;
   localparam int unsigned PhaseCount   = 12;
   localparam int unsigned PhaseItems   = 153;
   localparam int unsigned ReportLimit  = 10;

   // One row of the directed table: a register set or a request beat
   typedef struct {
      bit                                is_config;
      tvis_pkg::cfg_type                 cfg;
      tvis_pkg::op_type                  op;
      logic [tvis_pkg::ReadingWidth-1:0] reading;
      bit                                typed;
      tvis_pkg::result_type              want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tvis_req_intf req_if ();
   tvis_rsp_intf rsp_if ();
   tvis_csr_intf csr_if ();

   two_valve_irrigation_sequencer u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // Predicted sequencer state and settings
   tvis_pkg::cfg_type                     settings;
   logic                                  v1_open, v2_open, chain_on, auto_on;
   logic [tvis_pkg::TicksWidth-1:0]       v1_left, v2_left;
   logic [tvis_pkg::CountWidth-1:0]       dry_runs;

   tvis_pkg::result_type expected_results[$];
   stim_row_type         directed_rows[$];
   int unsigned          mismatch_count = 0;
   int unsigned          cycle_count = 0;
   bit                   req_steady = 1'b0;
   bit                   rsp_steady = 1'b0;

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("two_valve_irrigation_sequencer: mismatch");
         $finish;
      end
   end

   // Advance the predicted state by one beat and return the response it gives
   function automatic tvis_pkg::result_type sequence_step(
      input tvis_pkg::op_type op,
      input logic [tvis_pkg::ReadingWidth-1:0] reading
   );
      tvis_pkg::result_type            r;
      logic                            soil_dry;
      logic                            chained;
      logic                            suspended;
      logic [tvis_pkg::CountWidth-1:0] run_limit;
      soil_dry  = reading >= settings.dry_threshold;
      chained   = 1'b0;
      suspended = 1'b0;
      run_limit = (settings.dry_count_limit == '0) ? 4'd1 : settings.dry_count_limit;
      case (op)
         tvis_pkg::OP_SAMPLE: begin
            // valve two timer first, then valve one with chaining
            if (v2_open) begin
               if (v2_left <= 1) begin
                  v2_open = 1'b0;
                  v2_left = '0;
               end else begin
                  v2_left = v2_left - 1;
               end
            end
            if (v1_open) begin
               if (v1_left <= 1) begin
                  v1_open = 1'b0;
                  v1_left = '0;
                  if (chain_on) begin
                     v2_open = 1'b1;
                     v2_left = settings.valve_two_ticks;
                     chained = 1'b1;
                  end
                  if (soil_dry) begin
                     auto_on   = 1'b0;
                     suspended = 1'b1;
                  end
               end else begin
                  v1_left = v1_left - 1;
               end
            end
            // saturating dry run count, then automatic start
            if (soil_dry) begin
               if (dry_runs < run_limit) dry_runs = dry_runs + 1;
            end else begin
               dry_runs = '0;
            end
            if (!v1_open && !v2_open && auto_on && dry_runs == run_limit) begin
               v1_open = 1'b1;
               v1_left = settings.valve_one_ticks;
            end
         end
         tvis_pkg::OP_V1_ON: begin
            v1_open = 1'b1;
            v1_left = settings.valve_one_ticks;
         end
         tvis_pkg::OP_V1_OFF: begin
            v1_open = 1'b0;
            v1_left = '0;
         end
         tvis_pkg::OP_V2_ON: begin
            v2_open = 1'b1;
            v2_left = settings.valve_two_ticks;
         end
         tvis_pkg::OP_V2_OFF: begin
            v2_open = 1'b0;
            v2_left = '0;
         end
         tvis_pkg::OP_CHAIN_TOGGLE: chain_on = !chain_on;
         tvis_pkg::OP_AUTO_TOGGLE:  auto_on  = !auto_on;
         default: ;
      endcase
      r.valve_one_open   = v1_open;
      r.valve_two_open   = v2_open;
      r.chain_enabled    = chain_on;
      r.auto_enabled     = auto_on;
      r.chained_now      = chained;
      r.suspended_now    = suspended;
      r.humidity_percent = tvis_pkg::HumidityWidth'(100 - (int'(reading) * 100) / 1023);
      r.dry_run_count    = dry_runs;
      return r;
   endfunction

   function automatic string format_result(input tvis_pkg::result_type r);
      return $sformatf("v1=%0b v2=%0b chain=%0b auto=%0b chained=%0b susp=%0b hum=%0d dry=%0d",
                       r.valve_one_open, r.valve_two_open, r.chain_enabled,
                       r.auto_enabled, r.chained_now, r.suspended_now,
                       r.humidity_percent, r.dry_run_count);
   endfunction

   // Directed table builders
   function automatic void add_item(input tvis_pkg::op_type op, input int reading);
      stim_row_type row;
      row           = '{op: tvis_pkg::OP_STATUS, default: '0};
      row.op        = op;
      row.reading   = tvis_pkg::ReadingWidth'(reading);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_typed(input tvis_pkg::op_type op, input int reading,
                                     input tvis_pkg::result_type want);
      stim_row_type row;
      row           = '{op: tvis_pkg::OP_STATUS, default: '0};
      row.op        = op;
      row.reading   = tvis_pkg::ReadingWidth'(reading);
      row.typed     = 1'b1;
      row.want      = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_config(input tvis_pkg::cfg_type cfg);
      stim_row_type row;
      row           = '{op: tvis_pkg::OP_STATUS, default: '0};
      row.is_config = 1'b1;
      row.cfg       = cfg;
      directed_rows.push_back(row);
   endfunction

   // Readings biased around the dry threshold
   function automatic logic [tvis_pkg::ReadingWidth-1:0] pick_reading();
      int unsigned kind;
      int unsigned th;
      kind = $urandom_range(9, 0);
      th   = int'(settings.dry_threshold);
      if (kind < 4) return tvis_pkg::ReadingWidth'($urandom_range(1023, th));
      if (kind < 7 && th != 0) return tvis_pkg::ReadingWidth'($urandom_range(th - 1, 0));
      return tvis_pkg::ReadingWidth'($urandom_range(1023, 0));
   endfunction

   // Send one request beat; predict its response when it is taken
   task automatic send_request(input stim_row_type row);
      int unsigned          gap;
      tvis_pkg::result_type predicted;
      if ($urandom_range(39, 0) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(3, 0);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid            <= 1'b1;
      req_if.operation        <= row.op;
      req_if.moisture_reading <= row.reading;
      do @(posedge clock); while (!req_if.ready);
      predicted = sequence_step(row.op, row.reading);
      expected_results.push_back(row.typed ? row.want : predicted);
   endtask

   // Drop valid and let every outstanding response drain
   task automatic wait_quiet();
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input tvis_pkg::csr_index_type idx,
                                 input logic [tvis_pkg::CsrDataWidth-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // Write all four registers; unused upper bits carry junk
   task automatic write_settings(input tvis_pkg::cfg_type cfg);
      write_register(tvis_pkg::CSR_DRY_THRESHOLD,
                     {22'($urandom), cfg.dry_threshold});
      write_register(tvis_pkg::CSR_DRY_COUNT_LIMIT,
                     {28'($urandom), cfg.dry_count_limit});
      write_register(tvis_pkg::CSR_VALVE_ONE_TICKS, cfg.valve_one_ticks);
      write_register(tvis_pkg::CSR_VALVE_TWO_TICKS, cfg.valve_two_ticks);
      csr_if.valid <= 1'b0;
      settings = cfg;
   endtask

   task automatic check_response();
      tvis_pkg::result_type got;
      tvis_pkg::result_type want;
      got.valve_one_open   = rsp_if.valve_one_open;
      got.valve_two_open   = rsp_if.valve_two_open;
      got.chain_enabled    = rsp_if.chain_enabled;
      got.auto_enabled     = rsp_if.auto_enabled;
      got.chained_now      = rsp_if.chained_now;
      got.suspended_now    = rsp_if.suspended_now;
      got.humidity_percent = rsp_if.humidity_percent;
      got.dry_run_count    = rsp_if.dry_run_count;
      if (expected_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= ReportLimit)
            $display("ERROR: unexpected response beat: %s", format_result(got));
      end else begin
         want = expected_results.pop_front();
         if (got.valve_one_open   !== want.valve_one_open   ||
             got.valve_two_open   !== want.valve_two_open   ||
             got.chain_enabled    !== want.chain_enabled    ||
             got.auto_enabled     !== want.auto_enabled     ||
             got.chained_now      !== want.chained_now      ||
             got.suspended_now    !== want.suspended_now    ||
             got.humidity_percent !== want.humidity_percent ||
             got.dry_run_count    !== want.dry_run_count) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
               $display("ERROR: response mismatch at cycle %0d", cycle_count);
               $display("  expected %s", format_result(want));
               $display("  actual   %s", format_result(got));
            end
         end
      end
   endtask

   // Response side: random stall before each beat
   initial begin : response_sink
      int unsigned stall;
      rsp_if.ready = 1'b0;
      wait (!reset);
      forever begin
         if ($urandom_range(39, 0) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : $urandom_range(3, 0);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         check_response();
      end
   end

   // Stimulus
   initial begin : stimulus
      stim_row_type      row;
      tvis_pkg::cfg_type phase_cfg;
      req_if.valid            = 1'b0;
      req_if.operation        = tvis_pkg::OP_STATUS;
      req_if.moisture_reading = '0;
      csr_if.valid            = 1'b0;
      csr_if.index            = tvis_pkg::CSR_DRY_THRESHOLD;
      csr_if.data             = '0;

      settings = '{tvis_pkg::DryThresholdReset, tvis_pkg::DryCountLimitReset,
                   tvis_pkg::ValveOneTicksReset, tvis_pkg::ValveTwoTicksReset};
      v1_open  = 1'b0;
      v2_open  = 1'b0;
      v1_left  = '0;
      v2_left  = '0;
      dry_runs = '0;
      chain_on = 1'b1;
      auto_on  = 1'b1;

      // Directed table: reset values, reading extremes, every command
      add_typed(tvis_pkg::OP_STATUS,       0,    '{0, 0, 1, 1, 0, 0, 100, 0});
      add_typed(tvis_pkg::OP_SAMPLE,       1023, '{0, 0, 1, 1, 0, 0, 0,   1});
      add_typed(tvis_pkg::OP_SAMPLE,       767,  '{0, 0, 1, 1, 0, 0, 26,  0});
      add_typed(tvis_pkg::OP_SAMPLE,       768,  '{0, 0, 1, 1, 0, 0, 25,  1});
      add_typed(tvis_pkg::OP_CHAIN_TOGGLE, 0,    '{0, 0, 0, 1, 0, 0, 100, 1});
      add_typed(tvis_pkg::OP_CHAIN_TOGGLE, 1023, '{0, 0, 1, 1, 0, 0, 0,   1});
      add_typed(tvis_pkg::OP_AUTO_TOGGLE,  512,  '{0, 0, 1, 0, 0, 0, 50,  1});
      add_typed(tvis_pkg::OP_AUTO_TOGGLE,  511,  '{0, 0, 1, 1, 0, 0, 51,  1});
      add_typed(tvis_pkg::OP_V1_ON,        0,    '{1, 0, 1, 1, 0, 0, 100, 1});
      add_typed(tvis_pkg::OP_V2_ON,        0,    '{1, 1, 1, 1, 0, 0, 100, 1});
      add_typed(tvis_pkg::OP_V1_OFF,       0,    '{0, 1, 1, 1, 0, 0, 100, 1});
      add_typed(tvis_pkg::OP_V2_OFF,       0,    '{0, 0, 1, 1, 0, 0, 100, 1});
      // dry run up to the limit starts valve one on its own
      repeat (6) add_item(tvis_pkg::OP_SAMPLE, 1023);
      add_item(tvis_pkg::OP_V1_OFF, 0);
      // limit zero acts as one, zero duration acts as one; expiry chains and suspends
      add_config('{10'd768, 4'd0, 32'd2, 32'd0});
      add_item(tvis_pkg::OP_SAMPLE, 0);
      add_item(tvis_pkg::OP_SAMPLE, 1023);
      add_item(tvis_pkg::OP_SAMPLE, 1023);
      add_item(tvis_pkg::OP_SAMPLE, 1023);
      add_item(tvis_pkg::OP_SAMPLE, 0);
      // valve two expires on the same tick as the chain reopens it
      add_config('{10'd768, 4'd3, 32'd1, 32'd1});
      add_item(tvis_pkg::OP_V1_ON, 0);
      add_item(tvis_pkg::OP_V2_ON, 0);
      add_item(tvis_pkg::OP_SAMPLE, 0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_config) begin
            wait_quiet();
            write_settings(directed_rows[i].cfg);
         end else begin
            send_request(directed_rows[i]);
         end
      end

      // Random phases, each under its own settings
      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: phase_cfg = '{10'd0, 4'd1, 32'd1, 32'd1};
            1: phase_cfg = '{10'd1023, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            2: phase_cfg = '{10'($urandom), 4'($urandom_range(15, 0)), $urandom, $urandom};
            default: phase_cfg = '{10'($urandom_range(1000, 500)), 4'($urandom_range(15, 0)),
                                   32'($urandom_range(12, 0)), 32'($urandom_range(12, 0))};
         endcase
         wait_quiet();
         write_settings(phase_cfg);
         for (int n = 0; n < PhaseItems; n++) begin
            row         = '{op: tvis_pkg::OP_STATUS, default: '0};
            row.op      = ($urandom_range(9, 0) < 6) ? tvis_pkg::OP_SAMPLE
                                                     : tvis_pkg::op_type'($urandom_range(7, 1));
            row.reading = pick_reading();
            send_request(row);
         end
      end

      wait_quiet();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("two_valve_irrigation_sequencer: match");
      end else begin
         $display("two_valve_irrigation_sequencer: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/tvis_pkg.sv
src/tvis_intf.sv
src/tvis_csr.sv
src/tvis_core.sv
src/two_valve_irrigation_sequencer.sv
tb/testbench.sv
